// ----- rtl/pds_pkg.sv -----
package pds_pkg;

  // Extent of the walk.
  localparam int unsigned BUS_COUNT  = 8;
  localparam int unsigned SLOT_COUNT = 32;

  localparam int unsigned BUS_W    = 3;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration space constants.
  localparam logic [ID_W-1:0] ABSENT_VENDOR  = 16'hFFFF;
  localparam logic [7:0]      HEADER_OFFSET  = 8'h0C;
  localparam logic [7:0]      PROBE_OFFSET   = 8'h00;
  localparam logic [7:0]      OFFSET_MASK    = 8'hFC;
  localparam int unsigned     MULTI_BIT_POS  = 23;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_VENDOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_DEVICE = 2'd1;

  // Input item kinds.
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  // Result item kinds.
  localparam logic RESULT_REQUEST = 1'b0;
  localparam logic RESULT_FINISH  = 1'b1;

  typedef enum logic [2:0] {
    PH_PROBE  = 3'b001,
    PH_HEADER = 3'b010,
    PH_FUNC   = 3'b100
  } phase_t;

  typedef struct packed {
    logic              kind;
    logic [31:0]       read_data;
  } item_t;

  typedef struct packed {
    logic              result_kind;
    logic [31:0]       read_address;
    logic              found_flag;
    logic [BUS_W-1:0]  found_bus;
    logic [SLOT_W-1:0] found_slot;
    logic [FUNC_W-1:0] found_func;
  } result_t;

  // Position and mode of the walk.
  typedef struct packed {
    logic              busy;
    phase_t            phase;
    logic [BUS_W-1:0]  bus_index;
    logic [SLOT_W-1:0] slot_index;
    logic [FUNC_W-1:0] func_index;
    logic              multi_function;
  } walk_t;

  // Configuration address word with the enable bit set.
  function automatic logic [31:0] cfg_address(input logic [BUS_W-1:0]  b,
                                              input logic [SLOT_W-1:0] s,
                                              input logic [FUNC_W-1:0] f,
                                              input logic [7:0]        off);
    logic [31:0] a;
    a = 32'h8000_0000;
    a[16 +: BUS_W]  = b;
    a[11 +: SLOT_W] = s;
    a[8  +: FUNC_W] = f;
    a[7:0]          = off & OFFSET_MASK;
    return a;
  endfunction

endpackage

// ----- rtl/pds_step.sv -----
module pds_step (
  input  pds_pkg::walk_t        walk,
  input  pds_pkg::item_t        item,
  input  logic [15:0]           target_vendor,
  input  logic [15:0]           target_device,
  output pds_pkg::walk_t        walk_next,
  output logic                  emit,
  output pds_pkg::result_t      result
);
  import pds_pkg::*;

  logic [ID_W-1:0]   vend;
  logic [ID_W-1:0]   dev;
  logic              present;
  logic              match;
  logic [SLOT_W:0]   slot_inc;
  logic [BUS_W:0]    bus_inc;
  logic [BUS_W:0]    bus_step;
  logic [SLOT_W-1:0] slot_step;
  logic              walk_end;
  logic              last_func;
  walk_t             slot_walk;
  result_t           slot_result;
  result_t           request;

  assign vend    = item.read_data[15:0];
  assign dev     = item.read_data[31:16];
  assign present = (vend != ABSENT_VENDOR);
  assign match   = present && (vend == target_vendor) && (dev == target_device);

  // Next slot, carrying into the next bus.
  assign slot_inc = {1'b0, walk.slot_index} + 1'b1;
  assign bus_inc  = {1'b0, walk.bus_index} + 1'b1;

  always_comb begin
    if (slot_inc >= (SLOT_W+1)'(SLOT_COUNT)) begin
      slot_step = '0;
      bus_step  = bus_inc;
    end else begin
      slot_step = slot_inc[SLOT_W-1:0];
      bus_step  = {1'b0, walk.bus_index};
    end
    walk_end = (bus_step >= (BUS_W+1)'(BUS_COUNT));
  end

  // Outcome of moving on to the next slot: its probe or the not-found finish.
  always_comb begin
    slot_walk            = walk;
    slot_walk.func_index = '0;
    slot_walk.phase      = PH_PROBE;
    slot_result          = '0;
    if (walk_end) begin
      slot_walk.busy          = 1'b0;
      slot_walk.bus_index     = '0;
      slot_walk.slot_index    = '0;
      slot_result.result_kind = RESULT_FINISH;
    end else begin
      slot_walk.bus_index      = bus_step[BUS_W-1:0];
      slot_walk.slot_index     = slot_step;
      slot_result.result_kind  = RESULT_REQUEST;
      slot_result.read_address = cfg_address(bus_step[BUS_W-1:0], slot_step, '0,
                                             PROBE_OFFSET);
    end
  end

  assign last_func = !walk.multi_function || (walk.func_index == '1);

  // One step of the walk per item beat: a start item begins an idle walk, a data item advances a busy one.
  always_comb begin
    walk_next = walk;
    emit      = 1'b0;
    request   = '0;
    result    = '0;
    if (item.kind == KIND_START) begin
      if (!walk.busy) begin
        walk_next = '{busy: 1'b1, phase: PH_PROBE, default: '0};
        emit      = 1'b1;
        result.result_kind  = RESULT_REQUEST;
        result.read_address = cfg_address('0, '0, '0, PROBE_OFFSET);
      end
    end else if (walk.busy) begin
      emit = 1'b1;
      request.result_kind = RESULT_REQUEST;
      unique case (walk.phase)
        PH_HEADER: begin
          walk_next.multi_function = item.read_data[MULTI_BIT_POS];
          walk_next.phase          = PH_FUNC;
          walk_next.func_index     = '0;
          request.read_address = cfg_address(walk.bus_index, walk.slot_index, '0,
                                             PROBE_OFFSET);
          result = request;
        end
        PH_FUNC: begin
          if (match) begin
            walk_next.busy     = 1'b0;
            walk_next.phase    = PH_PROBE;
            result.result_kind = RESULT_FINISH;
            result.found_flag  = 1'b1;
            result.found_bus   = walk.bus_index;
            result.found_slot  = walk.slot_index;
            result.found_func  = walk.func_index;
          end else if (!last_func) begin
            walk_next.func_index = walk.func_index + 1'b1;
            request.read_address = cfg_address(walk.bus_index, walk.slot_index,
                                               walk.func_index + 1'b1, PROBE_OFFSET);
            result = request;
          end else begin
            walk_next = slot_walk;
            result    = slot_result;
          end
        end
        default: begin
          // Slot probe: skip an empty slot, else read its header dword.
          if (!present) begin
            walk_next = slot_walk;
            result    = slot_result;
          end else begin
            walk_next.phase      = PH_HEADER;
            request.read_address = cfg_address(walk.bus_index, walk.slot_index, '0,
                                               HEADER_OFFSET);
            result = request;
          end
        end
      endcase
    end
  end

endmodule

// ----- rtl/pci_device_search_sequencer.sv -----
// A result enters the result register in the cycle after its item beat.
// Throughput: one item per cycle; the walk state and the result register are
// updated together by a single combinational step, so only a stalled result stops input.
// Reset (rst, synchronous, active high) clears the walk to idle at bus 0, slot 0,
// empties the result register and sets both target IDs to 0.
module pci_device_search_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  pds_pkg::item_t                    item,
  output logic                              result_valid,
  input  logic                              result_ready,
  output pds_pkg::result_t                  result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                       cfg_data
);
  import pds_pkg::*;

  logic [ID_W-1:0] target_vendor;
  logic [ID_W-1:0] target_device;
  walk_t           walk;
  walk_t           walk_next;
  logic            emit;
  result_t         step_result;
  logic            item_beat;

  assign cfg_ready  = 1'b1;
  assign item_ready = !result_valid || result_ready;
  assign item_beat  = item_valid && item_ready;

  // Target ID registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_vendor <= '0;
      target_device <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TARGET_VENDOR: target_vendor <= cfg_data;
        REG_TARGET_DEVICE: target_device <= cfg_data;
        default: ;
      endcase
    end
  end

  pds_step u_step (
    .walk          (walk),
    .item          (item),
    .target_vendor (target_vendor),
    .target_device (target_device),
    .walk_next     (walk_next),
    .emit          (emit),
    .result        (step_result)
  );

  // Walk state advances on every accepted item beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= '{busy: 1'b0, phase: PH_PROBE, default: '0};
    end else if (item_beat) begin
      walk <= walk_next;
    end
  end

  // Result register; refilled in the same cycle it drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_beat && emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_beat && emit) begin
      result <= step_result;
    end
  end

endmodule
